FILE: design/cramer_3x3_solver_defines.svh
// Assertion helpers for the Cramer solver.
`ifndef CRAMER_3X3_SOLVER_DEFINES_SVH
`define CRAMER_3X3_SOLVER_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define CRS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another a fixed number of cycles later.
`define CRS_ASSERT_DELAY(label, clk, rst, ante, n, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error(msg);

`endif

FILE: design/crs_pkg.sv
package crs_pkg;

   localparam int COEF_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int FIELD_W        = 16;
   localparam int SOL_W          = 48;

   typedef struct packed {
      logic signed [FIELD_W-1:0] c1_x;
      logic signed [FIELD_W-1:0] c1_y;
      logic signed [FIELD_W-1:0] c1_z;
      logic signed [FIELD_W-1:0] c2_x;
      logic signed [FIELD_W-1:0] c2_y;
      logic signed [FIELD_W-1:0] c2_z;
      logic signed [FIELD_W-1:0] c3_x;
      logic signed [FIELD_W-1:0] c3_y;
      logic signed [FIELD_W-1:0] c3_z;
      logic signed [FIELD_W-1:0] rhs_x;
      logic signed [FIELD_W-1:0] rhs_y;
      logic signed [FIELD_W-1:0] rhs_z;
   } req_type;

   typedef struct packed {
      logic signed [SOL_W-1:0] sol_x;
      logic signed [SOL_W-1:0] sol_y;
      logic signed [SOL_W-1:0] sol_z;
      logic                    singular;
      logic                    saturated;
   } rsp_type;

   // Operand pairs of the eighteen 2x2 products; minor i is P[2i] - P[2i+1].
   localparam logic [3:0] MUL_A [18] = '{4'd4, 4'd5, 4'd5, 4'd3, 4'd3, 4'd6,
                                          4'd7, 4'd1, 4'd0, 4'd2, 4'd1, 4'd7,
                                          4'd1, 4'd2, 4'd2, 4'd0, 4'd0, 4'd1};
   localparam logic [3:0] MUL_B [18] = '{4'd8, 4'd7, 4'd6, 4'd8, 4'd7, 4'd4,
                                          4'd2, 4'd8, 4'd8, 4'd6, 4'd6, 4'd0,
                                          4'd5, 4'd4, 4'd3, 4'd5, 4'd4, 4'd3};

endpackage

FILE: design/cramer_3x3_solver.sv
// Solves x*c1 + y*c2 + z*c3 = rhs by Cramer's rule, one system per clock.
// A beat is taken whenever start is high (busy stays low: the pipeline never
// stalls) and its result appears on rsp_data with rsp_valid high for exactly
// one cycle, after the beat has passed through the whole pipeline, which holds 7
// stages of determinant/cofactor arithmetic, one restoring divider stage per
// quotient bit (49 bits: 48 output bits plus an overflow bit), a rounding stage
// and the output register. The receiver cannot stall, so it must take every
// rsp_valid beat. Results are fixed point with FRAC_BITS fraction bits, rounded
// to nearest with ties away from zero and clamped to 48 bits (saturated set).
// A zero determinant gives a zero vector with singular set. Only the low
// COEF_WIDTH bits of each field are used.
module cramer_3x3_solver #(
   parameter int COEF_WIDTH = crs_pkg::COEF_WIDTH_DEF,
   parameter int FRAC_BITS  = crs_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  crs_pkg::req_type req_data,
   output logic             rsp_valid,
   output crs_pkg::rsp_type rsp_data
);
   import crs_pkg::*;
   `include "cramer_3x3_solver_defines.svh"

   localparam int W   = COEF_WIDTH;
   localparam int PW  = 2 * W;          // 2x2 product
   localparam int MNW = 2 * W + 1;      // minor
   localparam int TW  = 3 * W + 1;      // coefficient times minor
   localparam int MW  = 3 * W + 3;      // determinant / numerator
   localparam int QB  = SOL_W + 1;      // quotient bits incl. overflow bit
   localparam int RW  = MW + QB + 1;    // divider remainder width
   localparam int LATENCY = 9 + QB;

   localparam logic [QB:0] LIM_POS = (QB+1)'((64'd1 << (SOL_W - 1)) - 64'd1);
   localparam logic [QB:0] LIM_NEG = (QB+1)'(64'd1 << (SOL_W - 1));

   // Valid bits travel alongside the data.
   logic [LATENCY-1:0] vld_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LATENCY-2:0], start & ~busy};
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: take the low W bits of each field (zero-padded) as a signed value.
   // ---------------------------------------------------------------
   logic [FIELD_W-1:0]  fld_in [12];
   logic signed [W-1:0] coef_ff [9];
   logic signed [W-1:0] rhs_ff1 [3];

   always_comb begin
      fld_in = '{req_data.c1_x, req_data.c1_y, req_data.c1_z,
                 req_data.c2_x, req_data.c2_y, req_data.c2_z,
                 req_data.c3_x, req_data.c3_y, req_data.c3_z,
                 req_data.rhs_x, req_data.rhs_y, req_data.rhs_z};
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 9; i++) begin
         coef_ff[i] <= signed'(W'({{W{1'b0}}, fld_in[i]}));
      end
      for (int i = 0; i < 3; i++) begin
         rhs_ff1[i] <= signed'(W'({{W{1'b0}}, fld_in[9+i]}));
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: eighteen 2x2 products. Carry the expansion row and rhs.
   // ---------------------------------------------------------------
   logic signed [PW-1:0] prod_ff [18];
   logic signed [W-1:0]  col_ff2 [3];
   logic signed [W-1:0]  rhs_ff2 [3];

   always_ff @(posedge clock) begin
      for (int i = 0; i < 18; i++) begin
         prod_ff[i] <= coef_ff[MUL_A[i]] * coef_ff[MUL_B[i]];
      end
      for (int i = 0; i < 3; i++) begin
         col_ff2[i] <= coef_ff[3*i];
         rhs_ff2[i] <= rhs_ff1[i];
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: the nine cofactors.
   // ---------------------------------------------------------------
   logic signed [MNW-1:0] minor_ff [9];
   logic signed [W-1:0]   col_ff3 [3];
   logic signed [W-1:0]   rhs_ff3 [3];

   always_ff @(posedge clock) begin
      for (int i = 0; i < 9; i++) begin
         minor_ff[i] <= MNW'(prod_ff[2*i]) - MNW'(prod_ff[2*i+1]);
      end
      col_ff3 <= col_ff2;
      rhs_ff3 <= rhs_ff2;
   end

   // ---------------------------------------------------------------
   // Stage 4: coefficient times cofactor terms.
   // Determinant expands down the first row of [c1 c2 c3].
   // ---------------------------------------------------------------
   logic signed [TW-1:0] det_term_ff [3];
   logic signed [TW-1:0] num_term_ff [3][3];

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         det_term_ff[i] <= col_ff3[i] * minor_ff[3*i];
         for (int k = 0; k < 3; k++) begin
            num_term_ff[k][i] <= rhs_ff3[i] * minor_ff[3*k+i];
         end
      end
   end

   // ---------------------------------------------------------------
   // Stage 5: sum the terms.
   // ---------------------------------------------------------------
   logic signed [MW-1:0] det_ff;
   logic signed [MW-1:0] num_ff [3];

   always_ff @(posedge clock) begin
      det_ff <= MW'(det_term_ff[0]) + MW'(det_term_ff[1]) + MW'(det_term_ff[2]);
      for (int k = 0; k < 3; k++) begin
         num_ff[k] <= MW'(num_term_ff[k][0]) + MW'(num_term_ff[k][1])
                    + MW'(num_term_ff[k][2]);
      end
   end

   // ---------------------------------------------------------------
   // Stage 6: magnitudes, quotient signs, singular flag.
   // ---------------------------------------------------------------
   logic [MW-1:0] den_mag_ff;
   logic [MW-1:0] num_mag_ff [3];
   logic [2:0]    neg_ff6;
   logic          sing_ff6;

   always_ff @(posedge clock) begin
      den_mag_ff <= det_ff[MW-1] ? unsigned'(-det_ff) : unsigned'(det_ff);
      for (int k = 0; k < 3; k++) begin
         num_mag_ff[k] <= num_ff[k][MW-1] ? unsigned'(-num_ff[k])
                                          : unsigned'(num_ff[k]);
         neg_ff6[k]    <= num_ff[k][MW-1] ^ det_ff[MW-1];
      end
      sing_ff6 <= (det_ff == '0);
   end

   // ---------------------------------------------------------------
   // Stage 7: scale by 2^FRAC_BITS, flag quotients of 2^QB or more.
   // Feeds divider slot 0.
   // ---------------------------------------------------------------
   logic [RW-1:0] rem_ff [QB+1][3];
   logic [QB-1:0] quo_ff [QB+1][3];
   logic [MW-1:0] den_ff [QB+1];
   logic [2:0]    neg_ff [QB+1];
   logic [2:0]    ovf_ff [QB+1];
   logic          sing_ff [QB+1];

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         rem_ff[0][k] <= RW'(num_mag_ff[k]) << FRAC_BITS;
         quo_ff[0][k] <= '0;
         ovf_ff[0][k] <= ((RW'(num_mag_ff[k]) << FRAC_BITS) >= (RW'(den_mag_ff) << QB));
      end
      den_ff[0]  <= den_mag_ff;
      neg_ff[0]  <= neg_ff6;
      sing_ff[0] <= sing_ff6;
   end

   // ---------------------------------------------------------------
   // Divider: one restoring step per stage, most significant bit first.
   // ---------------------------------------------------------------
   for (genvar s = 0; s < QB; s++) begin : g_div
      localparam int BIT = QB - 1 - s;
      logic [RW-1:0] sub_in;
      logic [RW-1:0] rem_in [3];
      logic [2:0]    take_in;

      always_comb begin
         sub_in = RW'(den_ff[s]) << BIT;
         for (int k = 0; k < 3; k++) begin
            take_in[k] = (rem_ff[s][k] >= sub_in);
            rem_in[k]  = take_in[k] ? (rem_ff[s][k] - sub_in) : rem_ff[s][k];
         end
      end

      always_ff @(posedge clock) begin
         for (int k = 0; k < 3; k++) begin
            rem_ff[s+1][k] <= rem_in[k];
            quo_ff[s+1][k] <= {quo_ff[s][k][QB-2:0], take_in[k]};
         end
         den_ff[s+1]  <= den_ff[s];
         neg_ff[s+1]  <= neg_ff[s];
         ovf_ff[s+1]  <= ovf_ff[s];
         sing_ff[s+1] <= sing_ff[s];
      end
   end

   // ---------------------------------------------------------------
   // Rounding stage: round half away from zero, then clamp.
   // ---------------------------------------------------------------
   logic [SOL_W-1:0] mag_ff [3];
   logic [2:0]       sat_ff;
   logic [2:0]       rneg_ff;
   logic             rsing_ff;
   logic [QB:0]      rnd_q_in [3];
   logic [QB:0]      lim_in [3];
   logic [2:0]       sat_in;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         rnd_q_in[k] = {1'b0, quo_ff[QB][k]}
                     + (QB+1)'(!ovf_ff[QB][k]
                        && ({rem_ff[QB][k][MW-1:0], 1'b0} >= {1'b0, den_ff[QB]}));
         lim_in[k]   = neg_ff[QB][k] ? LIM_NEG : LIM_POS;
         sat_in[k]   = ovf_ff[QB][k] || (rnd_q_in[k] > lim_in[k]);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         mag_ff[k] <= sat_in[k] ? lim_in[k][SOL_W-1:0] : rnd_q_in[k][SOL_W-1:0];
      end
      sat_ff   <= sat_in;
      rneg_ff  <= neg_ff[QB];
      rsing_ff <= sing_ff[QB];
   end

   // ---------------------------------------------------------------
   // Output register: apply the sign, force zero on a singular system.
   // ---------------------------------------------------------------
   rsp_type rsp_in;
   rsp_type rsp_ff;
   logic [SOL_W-1:0] sol_in [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sol_in[k] = rsing_ff ? '0 : (rneg_ff[k] ? (~mag_ff[k] + 1'b1) : mag_ff[k]);
      end
      rsp_in.sol_x     = signed'(sol_in[0]);
      rsp_in.sol_y     = signed'(sol_in[1]);
      rsp_in.sol_z     = signed'(sol_in[2]);
      rsp_in.singular  = rsing_ff;
      rsp_in.saturated = !rsing_ff && (sat_ff != '0);
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = vld_ff[LATENCY-1];
   assign rsp_data  = rsp_ff;

   // Every beat taken comes out as a rsp_valid beat, and no other beat appears.
   `CRS_ASSERT_DELAY(a_beat_out, clock, reset, start && !busy, LATENCY, rsp_valid, "beat lost")
   `CRS_ASSERT_IMPLY(a_beat_src, clock, reset, rsp_valid, $past(start, LATENCY), "beat invented")
   `CRS_ASSERT_IMPLY(a_sing_zero, clock, reset, rsp_valid && rsp_data.singular,
                     rsp_data.sol_x == '0 && rsp_data.sol_y == '0
                     && rsp_data.sol_z == '0 && !rsp_data.saturated,
                     "singular result not zero")

endmodule

FILE: tb/cramer_3x3_solver_tb.sv
`timescale 1ns / 1ps

module cramer_3x3_solver_tb;
   import crs_pkg::*;

   localparam int FRAC       = FRAC_BITS_DEF;
   localparam int DRAIN      = 120;     // well past the pipeline depth
   localparam int STALL_MAX  = 3000;    // cycles with no beat before we give up

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   // Solutions still owed by the pipeline, oldest first.
   rsp_type solution_queue[$];
   int      error_count = 0;
   int      systems_sent = 0;
   int      solutions_seen = 0;
   int      singular_seen = 0;
   int      saturated_seen = 0;
   int      quiet_cycles = 0;
   bit      beat_taken;
   int      idle_pct = 0;

   cramer_3x3_solver dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Divide num * 2^FRAC by den with round-half-away and 48-bit clamping,
   // done as long division so the scaled numerator never overflows 64 bits.
   function automatic logic [SOL_W-1:0] fixed_quotient(longint num, longint den,
                                                       inout bit sat);
      bit              neg;
      bit              over;
      longint unsigned n, d, q, r, lim;
      neg  = (num < 0) != (den < 0);
      n    = (num < 0) ? -num : num;
      d    = (den < 0) ? -den : den;
      over = 1'b0;
      if (n == 0) return '0;
      q = n / d;
      r = n % d;
      if (q >= (64'd1 << SOL_W)) over = 1'b1;
      for (int i = 0; i < FRAC && !over; i++) begin
         if (q >= (64'd1 << (SOL_W-1))) begin
            over = 1'b1;
            break;
         end
         r = r << 1;
         q = q << 1;
         if (r >= d) begin
            r = r - d;
            q = q | 64'd1;
         end
      end
      if (!over && 2 * r >= d) q = q + 1;
      lim = neg ? (64'd1 << (SOL_W-1)) : ((64'd1 << (SOL_W-1)) - 1);
      if (over || q > lim) begin
         q   = lim;
         sat = 1'b1;
      end
      if (neg) q = -q;
      return q[SOL_W-1:0];
   endfunction

   // Cramer's rule on the matrix whose columns are c1, c2, c3.
   function automatic rsp_type solve_system(req_type s);
      longint  a0, a1, a2, a3, a4, a5, a6, a7, a8, r0, r1, r2;
      longint  det, nx, ny, nz;
      bit      sat;
      rsp_type o;
      a0 = s.c1_x;  a1 = s.c1_y;  a2 = s.c1_z;
      a3 = s.c2_x;  a4 = s.c2_y;  a5 = s.c2_z;
      a6 = s.c3_x;  a7 = s.c3_y;  a8 = s.c3_z;
      r0 = s.rhs_x; r1 = s.rhs_y; r2 = s.rhs_z;
      sat = 1'b0;
      o   = '0;
      det = a0 * (a4*a8 - a5*a7) - a3 * (a1*a8 - a2*a7) + a6 * (a1*a5 - a2*a4);
      if (det == 0) begin
         o.singular = 1'b1;
         return o;
      end
      nx = r0 * (a4*a8 - a5*a7) + r1 * (a5*a6 - a3*a8) + r2 * (a3*a7 - a6*a4);
      ny = r0 * (a7*a2 - a1*a8) + r1 * (a0*a8 - a2*a6) + r2 * (a1*a6 - a7*a0);
      nz = r0 * (a1*a5 - a2*a4) + r1 * (a2*a3 - a0*a5) + r2 * (a0*a4 - a1*a3);
      o.sol_x     = fixed_quotient(nx, det, sat);
      o.sol_y     = fixed_quotient(ny, det, sat);
      o.sol_z     = fixed_quotient(nz, det, sat);
      o.saturated = sat;
      return o;
   endfunction

   // Send one system; called and returns at a falling edge, with start
   // high unless it drew idle gaps; back-to-back beats need no extra toggling.
   task automatic send_system(req_type s);
      req_data = s;
      start    = 1'b1;
      do @(posedge clock); while (busy);
      solution_queue.push_back(solve_system(s));
      systems_sent++;
      beat_taken = 1'b1;
      @(negedge clock);
      if (idle_pct > 0) begin
         while ($urandom_range(99, 0) < idle_pct) begin
            start = 1'b0;
            @(negedge clock);
         end
      end
   endtask

   task automatic send_matrix(int a0, int a1, int a2, int a3, int a4, int a5,
                              int a6, int a7, int a8, int r0, int r1, int r2);
      req_type s;
      s.c1_x  = FIELD_W'(a0); s.c1_y  = FIELD_W'(a1); s.c1_z  = FIELD_W'(a2);
      s.c2_x  = FIELD_W'(a3); s.c2_y  = FIELD_W'(a4); s.c2_z  = FIELD_W'(a5);
      s.c3_x  = FIELD_W'(a6); s.c3_y  = FIELD_W'(a7); s.c3_z  = FIELD_W'(a8);
      s.rhs_x = FIELD_W'(r0); s.rhs_y = FIELD_W'(r1); s.rhs_z = FIELD_W'(r2);
      send_system(s);
   endtask

   // Check every solution beat against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         beat_taken = 1'b1;
         solutions_seen++;
         if (solution_queue.size() == 0) begin
            $display("%0t: solution with nothing outstanding: %p", $realtime, rsp_data);
            error_count++;
         end else begin
            rsp_type want;
            want = solution_queue.pop_front();
            if (want.singular)  singular_seen++;
            if (want.saturated) saturated_seen++;
            if (rsp_data.sol_x !== want.sol_x) begin
               $display("%0t: sol_x expected %h actual %h", $realtime,
                        want.sol_x, rsp_data.sol_x);
               error_count++;
            end
            if (rsp_data.sol_y !== want.sol_y) begin
               $display("%0t: sol_y expected %h actual %h", $realtime,
                        want.sol_y, rsp_data.sol_y);
               error_count++;
            end
            if (rsp_data.sol_z !== want.sol_z) begin
               $display("%0t: sol_z expected %h actual %h", $realtime,
                        want.sol_z, rsp_data.sol_z);
               error_count++;
            end
            if (rsp_data.singular !== want.singular) begin
               $display("%0t: singular expected %b actual %b", $realtime,
                        want.singular, rsp_data.singular);
               error_count++;
            end
            if (rsp_data.saturated !== want.saturated) begin
               $display("%0t: saturated expected %b actual %b", $realtime,
                        want.saturated, rsp_data.saturated);
               error_count++;
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      #1;
      if (beat_taken) quiet_cycles = 0;
      else            quiet_cycles++;
      beat_taken = 1'b0;
      if (quiet_cycles >= STALL_MAX) begin
         $display("%0t: watchdog expired, %0d solutions outstanding", $realtime,
                  solution_queue.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // Corner matrices: extremes, singular, negative determinant, saturation.
   task automatic test_directed();
      send_matrix(1, 0, 0, 0, 1, 0, 0, 0, 1, 3, -4, 5);
      send_matrix(32767, 0, 0, 0, 32767, 0, 0, 0, 32767, 32767, -32768, 1);
      send_matrix(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768, 32767, -32768, -1);
      send_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 2, 3);            // all zero
      send_matrix(1, 2, 3, 2, 4, 6, 7, 8, 9, 5, 5, 5);            // dependent columns
      send_matrix(0, 1, 0, 1, 0, 0, 0, 0, 1, 7, 8, 9);            // negative det
      send_matrix(1, 0, 0, 32767, 1, 0, 32767, 32767, 1,
                  32767, -32768, 32767);                           // huge solution
      send_matrix(1, 0, 0, -32768, 1, 0, -32768, -32768, 1,
                  -32768, 32767, -32768);                          // huge, other sign
      send_matrix(3, 0, 0, 0, 3, 0, 0, 0, 3, 1, -1, 2);           // thirds round
      send_matrix(2, 0, 0, 0, 256, 0, 0, 0, 256, 1, -1, 0);       // zero numerator
      send_matrix(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                  32767, 32767, 32767);
      send_matrix(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                  -32768, -32768, -32768, -32768);
      send_matrix(32767, -32768, 0, -32768, 32767, 1, 0, 1, -32768,
                  -32768, 32767, -32768);
      send_matrix(-32768, 32767, -1, 1, -32768, 32767, 32767, -1, -32768,
                  32767, 0, -32768);
      send_matrix(65535, 1, 1, 1, 65535, 1, 1, 1, 65535, 1, 1, 1); // all -1/+1 bits
   endtask

   function automatic int pick_coef(int mode);
      case (mode)
         0:       return $urandom_range(65535, 0) - 32768;
         1:       return $urandom_range(4, 0) - 2;
         2:       return $urandom_range(255, 0) - 128;
         default: return $urandom_range(1, 0) ? 32767 - $urandom_range(3, 0)
                                              : -32768 + $urandom_range(3, 0);
      endcase
   endfunction

   task automatic test_random(int count);
      req_type s;
      int      mode;
      for (int k = 0; k < count; k++) begin
         mode = $urandom_range(3, 0);
         s.c1_x  = FIELD_W'(pick_coef(mode));
         s.c1_y  = FIELD_W'(pick_coef(mode));
         s.c1_z  = FIELD_W'(pick_coef(mode));
         s.c2_x  = FIELD_W'(pick_coef(mode));
         s.c2_y  = FIELD_W'(pick_coef(mode));
         s.c2_z  = FIELD_W'(pick_coef(mode));
         s.c3_x  = FIELD_W'(pick_coef(mode));
         s.c3_y  = FIELD_W'(pick_coef(mode));
         s.c3_z  = FIELD_W'(pick_coef(mode));
         s.rhs_x = FIELD_W'(pick_coef(0));
         s.rhs_y = FIELD_W'(pick_coef(mode));
         s.rhs_z = FIELD_W'(pick_coef(mode));
         // Make some systems singular by copying or scaling a column.
         if ($urandom_range(9, 0) == 0) begin
            s.c3_x = s.c1_x; s.c3_y = s.c1_y; s.c3_z = s.c1_z;
         end else if ($urandom_range(9, 0) == 0) begin
            s.c2_x = -s.c1_x; s.c2_y = -s.c1_y; s.c2_z = -s.c1_z;
         end
         send_system(s);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      idle_pct = 0;
      test_directed();
      test_random(450);
      idle_pct = 55;
      test_random(450);
      idle_pct = 33;
      test_random(250);
      idle_pct = 0;
      test_random(235);

      start = 1'b0;
      while (solution_queue.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);

      $display("Sent %0d systems, checked %0d solutions (%0d singular, %0d saturated).",
               systems_sent, solutions_seen, singular_seen, saturated_seen);
      $display("Sender gaps of 0, 55 and 33 percent; %0d mismatches.", error_count);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
